// ----- rtl/rug_pkg.sv -----
package rug_pkg;

	// id and statistics widths
	localparam int unsigned ID_W  = 16;
	localparam int unsigned CNT_W = 64;

	// used-map organisation: one row of bits per memory word
	localparam int unsigned MAP_ROW_W  = 32;
	localparam int unsigned MAP_BIT_W  = $clog2(MAP_ROW_W);
	localparam int unsigned MAP_ROW_AW = ID_W - MAP_BIT_W;
	localparam int unsigned MAP_ROWS   = (2 ** ID_W) / MAP_ROW_W;

	// ring of recently issued ids
	localparam int unsigned RING_DEPTH_DEF = 4096;

	// configuration port
	localparam int unsigned APB_AW = 3;
	localparam int unsigned APB_DW = 32;

	// register select, taken from address bit 2
	localparam logic REG_RANDOM_MODE  = 1'b0;
	localparam logic REG_STATS_ENABLE = 1'b1;

	// sequencer states
	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_TEST  = 5'b00100,
		ST_EVICT = 5'b01000,
		ST_SET   = 5'b10000
	} state_t;

endpackage

// ----- rtl/recent_unique_id_generator.sv -----
// channel | handshake                 | payload
// --------+---------------------------+-----------------------------------------------
// in      | in_valid / in_stall       | candidate
// out     | out_valid / out_stall     | issued_id, accepted, collision_total,
//         |                           | issued_total
// cfg     | psel, penable, pwrite ... | paddr, pwdata, prdata (0: random_mode,
//         |                           | 4: stats_enable)
//
// an accepted random id goes through accept, map lookup, map clear of the evicted id
// and map set, the clear left out while the ring has not yet wrapped; a rejected
// candidate or counter-mode item ends at lookup; the single used-map port sets this
// after reset a clearing pass writes the 2048 map rows, one a cycle, with in_stall high
// a finished item waits in the output register; only the last step of the next
// item waits on out_stall
module recent_unique_id_generator
	import rug_pkg::*;
#(
	parameter int unsigned RING_DEPTH = RING_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// input items
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [ID_W-1:0]       candidate,
	// result items
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [ID_W-1:0]       issued_id,
	output logic                  accepted,
	output logic [CNT_W-1:0]      collision_total,
	output logic [CNT_W-1:0]      issued_total,
	// configuration
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_AW-1:0]     paddr,
	input  logic [APB_DW-1:0]     pwdata,
	output logic [APB_DW-1:0]     prdata,
	output logic                  pready
);

	localparam int unsigned PTR_W = $clog2(RING_DEPTH);

	// memories
	logic [MAP_ROW_W-1:0] map_mem [MAP_ROWS];
	logic [ID_W-1:0]      ring_mem [RING_DEPTH];

	state_t state_q, state_d;

	logic                  random_mode_q, stats_enable_q;
	logic [MAP_ROW_AW-1:0] clr_cnt_q;
	logic [PTR_W-1:0]      ptr_q;
	logic                  wrapped_q;
	logic [ID_W-1:0]       seq_q;
	logic [CNT_W-1:0]      coll_q, iss_q;
	logic [ID_W-1:0]       cand_q;
	logic [MAP_ROW_W-1:0]  cand_row_q;
	logic [MAP_ROW_W-1:0]  map_rd_q;
	logic [ID_W-1:0]       ring_rd_q;
	logic                  out_valid_q;

	logic                  accept_in, out_free, res_fire;
	logic                  map_re, map_we;
	logic [MAP_ROW_AW-1:0] map_addr;
	logic [MAP_ROW_W-1:0]  map_wdata;
	logic                  hit, counter_mode, reject, ev_same_row;
	logic [MAP_ROW_W-1:0]  cand_mask, ev_mask;
	logic                  coll_inc, iss_inc;
	logic [ID_W-1:0]       res_id;
	logic                  res_ok;
	logic                  cfg_wr;

	// handshake
	assign in_stall  = (state_q != ST_IDLE);
	assign accept_in = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	// lookup decode
	assign cand_mask    = MAP_ROW_W'(1) << cand_q[MAP_BIT_W-1:0];
	assign ev_mask      = MAP_ROW_W'(1) << ring_rd_q[MAP_BIT_W-1:0];
	assign hit          = map_rd_q[cand_q[MAP_BIT_W-1:0]];
	assign counter_mode = !random_mode_q;
	assign reject       = random_mode_q && ((cand_q == '0) || hit);
	assign ev_same_row  = (ring_rd_q[ID_W-1:MAP_BIT_W] == cand_q[ID_W-1:MAP_BIT_W]);

	// map port arbitration: one access a cycle
	always_comb begin
		map_re    = 1'b0;
		map_we    = 1'b0;
		map_addr  = cand_q[ID_W-1:MAP_BIT_W];
		map_wdata = '0;
		unique case (state_q)
			ST_CLEAR: begin
				map_we   = 1'b1;
				map_addr = clr_cnt_q;
			end
			ST_IDLE: begin
				map_re   = accept_in;
				map_addr = candidate[ID_W-1:MAP_BIT_W];
			end
			ST_TEST: begin
				map_re   = !counter_mode && !reject && wrapped_q;
				map_addr = ring_rd_q[ID_W-1:MAP_BIT_W];
			end
			ST_EVICT: begin
				map_we    = 1'b1;
				map_addr  = ring_rd_q[ID_W-1:MAP_BIT_W];
				map_wdata = map_rd_q & ~ev_mask;
			end
			ST_SET: begin
				map_we    = 1'b1;
				map_wdata = cand_row_q | cand_mask;
			end
			default: begin
				map_re = 1'b0;
			end
		endcase
	end

	// used-map memory
	always_ff @(posedge clk) begin
		if (map_we) begin
			map_mem[map_addr] <= map_wdata;
		end else if (map_re) begin
			map_rd_q <= map_mem[map_addr];
		end
	end

	// ring memory: read at accept, written when the id is issued
	always_ff @(posedge clk) begin
		if (state_q == ST_SET && res_fire) begin
			ring_mem[ptr_q] <= cand_q;
		end else if (accept_in) begin
			ring_rd_q <= ring_mem[ptr_q];
		end
	end

	// result selection
	assign res_fire = out_free && ((state_q == ST_SET) ||
		(state_q == ST_TEST && (counter_mode || reject)));
	assign res_id   = counter_mode ? seq_q : ((state_q == ST_SET) ? cand_q : '0);
	assign res_ok   = counter_mode || (state_q == ST_SET);
	assign coll_inc = stats_enable_q && (state_q == ST_TEST) && random_mode_q &&
		(cand_q != '0) && hit;
	assign iss_inc  = stats_enable_q && (state_q == ST_SET);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_cnt_q == MAP_ROW_AW'(MAP_ROWS - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept_in) state_d = ST_TEST;
			end
			ST_TEST: begin
				if (counter_mode || reject) begin
					if (out_free) state_d = ST_IDLE;
				end else if (wrapped_q) begin
					state_d = ST_EVICT;
				end else begin
					state_d = ST_SET;
				end
			end
			ST_EVICT: begin
				state_d = ST_SET;
			end
			ST_SET: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_cnt_q   <= '0;
			ptr_q       <= '0;
			wrapped_q   <= 1'b0;
			seq_q       <= '0;
			coll_q      <= '0;
			iss_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_cnt_q <= clr_cnt_q + 1'b1;
			if (res_fire) begin
				out_valid_q <= 1'b1;
				coll_q      <= coll_q + CNT_W'(coll_inc);
				iss_q       <= iss_q + CNT_W'(iss_inc);
				if (counter_mode) seq_q <= seq_q + 1'b1;
				if (state_q == ST_SET) begin
					if (ptr_q == PTR_W'(RING_DEPTH - 1)) begin
						ptr_q     <= '0;
						wrapped_q <= 1'b1;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// item payload and output register
	always_ff @(posedge clk) begin
		if (accept_in) cand_q <= candidate;
		if (state_q == ST_TEST) begin
			cand_row_q <= map_rd_q;
		end else if (state_q == ST_EVICT && ev_same_row) begin
			cand_row_q <= cand_row_q & ~ev_mask;
		end
		if (res_fire) begin
			issued_id       <= res_id;
			accepted        <= res_ok;
			collision_total <= coll_q + CNT_W'(coll_inc);
			issued_total    <= iss_q + CNT_W'(iss_inc);
		end
	end

	// configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			random_mode_q  <= 1'b1;
			stats_enable_q <= 1'b0;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_RANDOM_MODE:  random_mode_q  <= pwdata[0];
				REG_STATS_ENABLE: stats_enable_q <= pwdata[0];
				default:          random_mode_q  <= random_mode_q;
			endcase
		end
	end

	// register read-back
	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			REG_RANDOM_MODE:  prdata[0] = random_mode_q;
			REG_STATS_ENABLE: prdata[0] = stats_enable_q;
			default:          prdata    = '0;
		endcase
	end

endmodule

// ----- rtl/rug_checker.sv -----
module rug_checker
	import rug_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_stall,
	input logic             out_valid,
	input logic             out_stall,
	input logic [ID_W-1:0]  issued_id,
	input logic             accepted
);

	// a rejected candidate never carries an id
	a_reject_zero_id: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !accepted) |-> (issued_id == '0))
		else $error("rejected item carries a nonzero id");

	// one item at a time: the input side closes right after an accept
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("second item taken while the first is in flight");

	// a new result only appears while an item is being worked on
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared with no item in flight");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(issued_id) && $stable(accepted)))
		else $error("stalled result changed");

endmodule

bind recent_unique_id_generator rug_checker u_rug_checker (.*);

// ----- tb/recent_unique_id_generator_tb.sv -----
module recent_unique_id_generator_tb
	import rug_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned RING_DEPTH = RING_DEPTH_DEF;
	localparam int unsigned ID_SPACE   = 2 ** ID_W;
	localparam longint      CYCLE_LIMIT = 600000;
	localparam int          FILL_ITEMS  = 100;

	// one result item as the block reports it
	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic             ok;
		logic [CNT_W-1:0] collisions;
		logic [CNT_W-1:0] issued;
	} id_result_t;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [ID_W-1:0]       candidate = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [ID_W-1:0]       issued_id;
	logic                  accepted;
	logic [CNT_W-1:0]      collision_total;
	logic [CNT_W-1:0]      issued_total;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_AW-1:0]     paddr = '0;
	logic [APB_DW-1:0]     pwdata = '0;
	logic [APB_DW-1:0]     prdata;
	logic                  pready;

	// predictor state
	bit              id_in_use [ID_SPACE];
	logic [ID_W-1:0] recent_ids [RING_DEPTH] = '{default: '0};
	int unsigned     evict_ptr = 0;
	logic [ID_W-1:0] seq_count = '0;
	logic [CNT_W-1:0] collision_cnt = '0;
	logic [CNT_W-1:0] issue_cnt = '0;
	logic            random_ids_on = 1'b1;
	logic            stats_on = 1'b0;

	// every id ever handed out in random mode, for re-offering later
	logic [ID_W-1:0] issued_log [$];

	logic [ID_W-1:0] candidate_fifo [$];
	id_result_t      expected_ids [$];
	int              items_queued = 0;
	int              results_seen = 0;
	int              error_count = 0;
	int              idle_pct = 30;
	longint          cycle_count = 0;

	recent_unique_id_generator #(
		.RING_DEPTH(RING_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.candidate(candidate),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.issued_id(issued_id),
		.accepted(accepted),
		.collision_total(collision_total),
		.issued_total(issued_total),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// work out the result of one candidate and update the predicted state
	function automatic id_result_t next_id_result(logic [ID_W-1:0] cand);
		id_result_t r;
		r.id = '0;
		r.ok = 1'b0;
		if (!random_ids_on) begin
			r.id = seq_count;
			r.ok = 1'b1;
			seq_count = seq_count + 1'b1;
		end else if (cand == '0) begin
			r.ok = 1'b0;
		end else if (id_in_use[cand]) begin
			if (stats_on)
				collision_cnt = collision_cnt + 1'b1;
		end else begin
			// evict the oldest id, record the new one
			id_in_use[recent_ids[evict_ptr]] = 1'b0;
			id_in_use[cand] = 1'b1;
			recent_ids[evict_ptr] = cand;
			evict_ptr = (evict_ptr + 1) % RING_DEPTH;
			if (stats_on)
				issue_cnt = issue_cnt + 1'b1;
			issued_log.push_back(cand);
			r.id = cand;
			r.ok = 1'b1;
		end
		r.collisions = collision_cnt;
		r.issued = issue_cnt;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [CNT_W-1:0] got, logic [CNT_W-1:0] want);
		$display("%0t mismatch on %s: got %0h, expected %0h", $time, what, got, want);
		error_count++;
	endtask

	// input driver: next item once the current one has gone in
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			if (candidate_fifo.size() > 0 && $urandom_range(99) >= idle_pct) begin
				in_valid <= 1'b1;
				candidate <= candidate_fifo.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// output back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(99) < idle_pct);
		end
	end

	// predict on accepted items, check accepted results
	always @(posedge clk) begin : check_results
		id_result_t want;
		if (arst_n) begin
			if (in_valid && !in_stall)
				expected_ids.push_back(next_id_result(candidate));
			if (out_valid && !out_stall) begin
				results_seen++;
				if (expected_ids.size() == 0) begin
					report_mismatch("unexpected result item", CNT_W'(issued_id), '0);
				end else begin
					want = expected_ids.pop_front();
					if (issued_id !== want.id)
						report_mismatch("issued_id", CNT_W'(issued_id), CNT_W'(want.id));
					if (accepted !== want.ok)
						report_mismatch("accepted", CNT_W'(accepted), CNT_W'(want.ok));
					if (collision_total !== want.collisions)
						report_mismatch("collision_total", collision_total, want.collisions);
					if (issued_total !== want.issued)
						report_mismatch("issued_total", issued_total, want.issued);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic write_reg(logic sel, logic value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {sel, 2'b00};
		pwdata <= {{(APB_DW-1){1'b0}}, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (sel == REG_RANDOM_MODE)
			random_ids_on = value;
		else
			stats_on = value;
	endtask

	task automatic send(logic [ID_W-1:0] cand);
		candidate_fifo.push_back(cand);
		items_queued++;
	endtask

	// wait for every expected result, then let the block settle
	task automatic drain();
		while (results_seen != items_queued)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// random candidates: zeros, extremes, re-offered ids and fresh values
	task automatic queue_random(int n);
		int r;
		int span;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 8) begin
				send('0);
			end else if (r < 14) begin
				case ($urandom_range(2))
					0: send('1);
					1: send(16'h0001);
					default: send(16'h8000);
				endcase
			end else if (r < 55 && issued_log.size() > 0) begin
				span = (issued_log.size() < 2 * RING_DEPTH) ? issued_log.size() : 2 * RING_DEPTH;
				send(issued_log[issued_log.size() - 1 - $urandom_range(span - 1)]);
			end else begin
				send(ID_W'($urandom_range(ID_SPACE - 1)));
			end
		end
	endtask

	// stimulus sequence
	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// let the map clearing pass finish
		while (in_stall)
			@(posedge clk);

		// random ids with statistics
		write_reg(REG_RANDOM_MODE, 1'b1);
		write_reg(REG_STATS_ENABLE, 1'b1);
		send('0);
		send('1);
		send(16'h0001);
		send('1);
		send(16'h8000);
		send(16'h7fff);
		send(16'h0001);
		send('0);
		send(16'haaaa);
		send(16'h5555);
		drain();

		// statistics frozen
		write_reg(REG_STATS_ENABLE, 1'b0);
		send('1);
		send(16'h1234);
		send('0);
		send(16'h1234);
		drain();

		// counter mode ignores the candidate
		write_reg(REG_RANDOM_MODE, 1'b0);
		send('0);
		send('1);
		send(16'h0001);
		send(16'h1234);
		drain();

		// long stretch of fresh ids with no idling
		write_reg(REG_RANDOM_MODE, 1'b1);
		write_reg(REG_STATS_ENABLE, 1'b1);
		idle_pct = 0;
		for (int i = 0; i < FILL_ITEMS; i++)
			send(ID_W'($urandom_range(ID_SPACE - 1, 1)));
		drain();
		idle_pct = 30;

		// random phases over every setting
		queue_random(100);
		drain();
		write_reg(REG_RANDOM_MODE, 1'b0);
		queue_random(30);
		drain();
		write_reg(REG_RANDOM_MODE, 1'b1);
		write_reg(REG_STATS_ENABLE, 1'b0);
		queue_random(80);
		drain();
		write_reg(REG_RANDOM_MODE, 1'b0);
		queue_random(30);
		drain();
		write_reg(REG_RANDOM_MODE, 1'b1);
		write_reg(REG_STATS_ENABLE, 1'b1);
		queue_random(42);
		drain();

		repeat (20) @(posedge clk);
		if (error_count == 0 && expected_ids.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
